// ===== rtl/smf7_pkg.sv =====
`timescale 1ns / 1ps

package smf7_pkg;

	// Filter geometry and sample format.
	localparam int RADIUS       = 3;
	localparam int SAMPLE_WIDTH = 16;
	localparam int WIN_LEN      = 2 * RADIUS + 1;
	localparam int MAX_RES      = RADIUS + 1;

	// Derived widths.
	localparam int POS_W    = $clog2(WIN_LEN + 1);
	localparam int WIDX_W   = $clog2(WIN_LEN);
	localparam int RANK_W   = $clog2(WIN_LEN);
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int IDX_W    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

	typedef logic signed [SAMPLE_WIDTH-1:0] smp_t;
	typedef smp_t [WIN_LEN-1:0] win_t;

	// Input word: one sample of a record.
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           record_last;
	} feed_t;

	// Output word: one filtered or passed-through sample.
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] value;
		logic                           is_median;
		logic                           run_end;
		logic                           record_end;
	} result_t;

	// Shifted window and its context, handed from the window stage to the emitter.
	typedef struct packed {
		win_t             win;
		logic [POS_W-1:0] pos;
		logic             last;
	} stage_t;

endpackage

// ===== rtl/smf7_median.sv =====
`timescale 1ns / 1ps

module smf7_median (
	input  smf7_pkg::win_t win,
	output smf7_pkg::smp_t median
);
	import smf7_pkg::*;

	logic [RANK_W-1:0] rank [WIN_LEN];

	// Rank every entry against all others; ties are broken by position so
	// that exactly one entry lands on the middle rank.
	always_comb begin
		for (int i = 0; i < WIN_LEN; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WIN_LEN; j++) begin
				if (j != i) begin
					if (($signed(win[j]) < $signed(win[i])) ||
					    ((win[j] == win[i]) && (j < i))) begin
						rank[i] = rank[i] + RANK_W'(1);
					end
				end
			end
		end
	end

	// Pick the entry whose rank is the middle one.
	always_comb begin
		median = '0;
		for (int i = 0; i < WIN_LEN; i++) begin
			if (rank[i] == RANK_W'(RADIUS)) begin
				median = median | win[i];
			end
		end
	end

endmodule

// ===== rtl/smf7_window.sv =====
`timescale 1ns / 1ps

module smf7_window (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             feed_valid,
	output logic             feed_ready,
	input  smf7_pkg::feed_t  feed,
	output logic             stage_valid,
	input  logic             stage_ready,
	output smf7_pkg::stage_t stage
);
	import smf7_pkg::*;

	win_t             window_q;
	logic [POS_W-1:0] pos_q;
	win_t             win_s1;
	logic [POS_W-1:0] pos_s1;
	logic             last_s1;
	logic             valid_s1;
	win_t             win_next;
	logic             take;

	// The stage register frees up when empty or when the emitter takes it.
	assign feed_ready = !valid_s1 || stage_ready;
	assign take       = feed_valid && feed_ready;

	// Window after shifting in the new sample, newest at index zero.
	always_comb begin
		win_next    = window_q;
		for (int i = WIN_LEN - 1; i > 0; i--) begin
			win_next[i] = window_q[i-1];
		end
		win_next[0] = feed.sample;
	end

	// Running window and position; both clear at the end of a record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
		end else if (take) begin
			if (feed.record_last) begin
				window_q <= '0;
				pos_q    <= '0;
			end else begin
				window_q <= win_next;
				if (pos_q < POS_W'(WIN_LEN)) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	// Stage register: shifted window, position before this sample, last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (stage_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			win_s1  <= win_next;
			pos_s1  <= pos_q;
			last_s1 <= feed.record_last;
		end
	end

	assign stage_valid = valid_s1;
	assign stage.win   = win_s1;
	assign stage.pos   = pos_s1;
	assign stage.last  = last_s1;

endmodule

// ===== rtl/smf7_emit.sv =====
`timescale 1ns / 1ps

module smf7_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             stage_valid,
	output logic             stage_ready,
	input  smf7_pkg::stage_t stage,
	output logic             result_valid,
	input  logic             result_ready,
	output smf7_pkg::result_t result
);
	import smf7_pkg::*;

	smp_t                 med;
	logic [POS_W-1:0]     top;
	logic                 has_first;
	logic                 first_med;
	smp_t                 first_val;
	logic [RES_CNT_W-1:0] cnt;
	logic [POS_W:0]       kk;
	smp_t                 slot_val [MAX_RES];
	logic [MAX_RES-1:0]   slot_med;
	smp_t                 value_s2 [MAX_RES];
	logic [MAX_RES-1:0]   med_s2;
	logic                 last_s2;
	logic [RES_CNT_W-1:0] rem_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 load;
	logic                 pop;

	smf7_median u_median (
		.win    (stage.win),
		.median (med)
	);

	// Build the group of words caused by one sample: the centered word once
	// enough samples came before, then the pending tail when the record ends.
	always_comb begin
		top       = (stage.pos < POS_W'(RADIUS)) ? stage.pos : POS_W'(RADIUS - 1);
		has_first = (stage.pos >= POS_W'(RADIUS));
		first_med = (stage.pos >= POS_W'(2 * RADIUS));
		first_val = first_med ? med : stage.win[RADIUS];
		cnt       = RES_CNT_W'(has_first) +
		            (stage.last ? (RES_CNT_W'(top) + RES_CNT_W'(1)) : RES_CNT_W'(0));
		kk        = '0;
		for (int j = 0; j < MAX_RES; j++) begin
			kk = {1'b0, top} + (POS_W+1)'(has_first) - (POS_W+1)'(j);
			if (kk < (POS_W+1)'(WIN_LEN)) begin
				slot_val[j] = stage.win[kk[WIDX_W-1:0]];
			end else begin
				slot_val[j] = '0;
			end
			slot_med[j] = 1'b0;
			if ((j == 0) && has_first) begin
				slot_val[j] = first_val;
				slot_med[j] = first_med;
			end
		end
	end

	// A new group loads when the current one is empty or its last word leaves.
	assign stage_ready = (rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && result_ready);
	assign load        = stage_valid && stage_ready;
	assign pop         = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= cnt;
			idx_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - RES_CNT_W'(1);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int j = 0; j < MAX_RES; j++) begin
				value_s2[j] <= slot_val[j];
			end
			med_s2  <= slot_med;
			last_s2 <= stage.last;
		end
	end

	// Drain the group one word per cycle while the receiver is ready.
	assign result_valid      = (rem_q != '0);
	assign result.value      = value_s2[idx_q];
	assign result.is_median  = med_s2[idx_q];
	assign result.run_end    = (rem_q == RES_CNT_W'(1));
	assign result.record_end = last_s2 && (rem_q == RES_CNT_W'(1));

	// The remaining count never exceeds one group.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= RES_CNT_W'(MAX_RES))
		else $error("word count exceeds group size");

	// Read index and remaining count stay within the loaded group.
	a_idx_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |->
		((RES_CNT_W+1)'(idx_q) + (RES_CNT_W+1)'(rem_q) <= (RES_CNT_W+1)'(MAX_RES)))
		else $error("read index runs past the group");

	// The record end mark only sits on the final word of a group.
	a_rec_run: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.record_end) |-> result.run_end)
		else $error("record end without run end");

	// A word taken mid-group leaves the rest of the group in place.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (rem_q > RES_CNT_W'(1))) |=> (rem_q == $past(rem_q) - RES_CNT_W'(1)))
		else $error("group drained out of order");

endmodule

// ===== rtl/sliding_median_filter_7_unit.sv =====
`timescale 1ns / 1ps

// Seven-tap sliding median filter over records of signed 16-bit samples.
// Feed channel (feed_valid/feed_ready/feed): one sample per word, with
// record_last set on the final sample of a record.
// Result channel (result_valid/result_ready/result): the record comes back
// in order, delayed by three samples. Interior samples are replaced by the
// median of the seven samples centered on them (is_median set); the first
// three and last three samples of a record pass through raw. The final
// sample flushes the pending samples, so one feed word gives up to four
// result words; run_end marks the last of them and record_end the word that
// carries the record's final sample.
// A word passes through the window stage register, then the output group register.
// Throughput: one feed word per cycle while each gives at most one result and
// the receiver is ready; a record end that yields k words holds the feed while
// the output group register drains them, one word per cycle as the receiver takes them.
// Reset clears the window, the position count and all pending words.
// When the receiver stalls, finished words wait in the output group register
// and one further sample waits in the window stage before feed_ready drops.
module sliding_median_filter_7_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              feed_valid,
	output logic              feed_ready,
	input  smf7_pkg::feed_t   feed,
	output logic              result_valid,
	input  logic              result_ready,
	output smf7_pkg::result_t result
);
	import smf7_pkg::*;

	stage_t stage;
	logic   stage_valid;
	logic   stage_ready;

	smf7_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.feed_valid  (feed_valid),
		.feed_ready  (feed_ready),
		.feed        (feed),
		.stage_valid (stage_valid),
		.stage_ready (stage_ready),
		.stage       (stage)
	);

	smf7_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_valid  (stage_valid),
		.stage_ready  (stage_ready),
		.stage        (stage),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== tb/sv/tb_sliding_median_filter_7_unit.sv =====
`timescale 1ns / 1ps

module tb_sliding_median_filter_7_unit;
	import smf7_pkg::*;

	localparam int LIMIT_CYCLES  = 300000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 50;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    feed_valid   = 1'b0;
	logic    feed_ready;
	feed_t   feed         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// Filter state kept by the testbench, newest sample first.
	smp_t        model_win [WIN_LEN];
	int unsigned model_pos;
	result_t     expected_words [$];

	int unsigned error_count   = 0;
	int unsigned words_fed     = 0;
	int unsigned records_fed   = 0;
	int unsigned words_checked = 0;
	int unsigned medians_seen  = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left     = 0;
	longint unsigned cycle_count = 0;

	sliding_median_filter_7_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.feed_valid   (feed_valid),
		.feed_ready   (feed_ready),
		.feed         (feed),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	// The run is cut off at a fixed cycle budget.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				expected_words.size());
			$display("sliding_median_filter_7_unit: mismatch");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] error: %s", $time, what);
	endtask

	// Median of the current window, by insertion sort on signed samples.
	function automatic smp_t median_of_window();
		smp_t sorted [WIN_LEN];
		smp_t key;
		int   j;
		for (int i = 0; i < WIN_LEN; i++)
			sorted[i] = model_win[i];
		for (int i = 1; i < WIN_LEN; i++) begin
			key = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > key) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = key;
		end
		return sorted[RADIUS];
	endfunction

	// Shift one accepted sample into the window and queue the words it causes.
	task automatic predict_filter_words(input smp_t s, input logic last);
		result_t     group [MAX_RES];
		result_t     w;
		int unsigned samples_before;
		int          top;
		int          n;
		samples_before = model_pos;
		n = 0;
		for (int i = WIN_LEN - 1; i > 0; i--)
			model_win[i] = model_win[i - 1];
		model_win[0] = s;

		// The sample RADIUS places back is now complete, unless the record is young.
		if (samples_before >= RADIUS) begin
			w = '0;
			if (samples_before >= 2 * RADIUS) begin
				w.value = median_of_window();
				w.is_median = 1'b1;
			end else begin
				w.value = model_win[RADIUS];
			end
			group[n] = w;
			n++;
		end

		// The final sample flushes every pending sample raw and clears the state.
		if (last) begin
			top = (samples_before < RADIUS) ? int'(samples_before) : RADIUS - 1;
			for (int k = top; k >= 0; k--) begin
				w = '0;
				w.value = model_win[k];
				w.record_end = (k == 0);
				group[n] = w;
				n++;
			end
			for (int i = 0; i < WIN_LEN; i++)
				model_win[i] = '0;
			model_pos = 0;
		end else if (model_pos < WIN_LEN) begin
			model_pos++;
		end

		if (n > 0)
			group[n - 1].run_end = 1'b1;
		for (int i = 0; i < n; i++)
			expected_words = {expected_words, group[i]};
	endtask

	// Compare every accepted result word with the oldest expected one.
	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word value %0d is_median %0b",
					result.value, result.is_median));
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (want.is_median)
					medians_seen++;
				if (result.value !== want.value)
					report_mismatch($sformatf("value %0d, expected %0d",
						result.value, want.value));
				if (result.is_median !== want.is_median)
					report_mismatch($sformatf("is_median %0b, expected %0b",
						result.is_median, want.is_median));
				if (result.run_end !== want.run_end)
					report_mismatch($sformatf("run_end %0b, expected %0b",
						result.run_end, want.run_end));
				if (result.record_end !== want.record_end)
					report_mismatch($sformatf("record_end %0b, expected %0b",
						result.record_end, want.record_end));
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one word, idling at random first; returns at the falling edge
	// after acceptance with valid still high.
	task automatic send_word(input smp_t s, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			feed_valid = 1'b0;
			@(negedge clk);
		end
		feed_valid = 1'b1;
		feed.sample = s;
		feed.record_last = last;
		@(posedge clk);
		while (!feed_ready)
			@(posedge clk);
		predict_filter_words(s, last);
		words_fed++;
		if (last)
			records_fed++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected word has come back.
	task automatic wait_drained();
		feed_valid = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Sample flavors: full range, a narrow band with many ties, the extremes, or a random pick of those.
	function automatic smp_t random_sample(input int unsigned flavor);
		case (flavor)
			0: return smp_t'($urandom);
			1: return smp_t'(int'($urandom_range(8)) - 4);
			2: begin
				case ($urandom_range(3))
					0: return smp_t'(16'sh8000);
					1: return smp_t'(16'sh7fff);
					2: return smp_t'(0);
					default: return smp_t'(-1);
				endcase
			end
			default: return random_sample($urandom_range(2));
		endcase
	endfunction

	task automatic send_record_of(input int unsigned len, input int unsigned flavor);
		for (int unsigned i = 0; i < len; i++)
			send_word(random_sample(flavor), i == len - 1);
	endtask

	// Records too short to fill a window pass through raw.
	task automatic test_short_records();
		send_word(16'sh7fff, 1'b1);
		send_word(16'sh8000, 1'b0);
		send_word(-16'sd1, 1'b0);
		send_word(16'sd0, 1'b1);
		send_word(16'sd1, 1'b0);
		send_word(-16'sd2, 1'b0);
		send_word(16'sd3, 1'b0);
		send_word(-16'sd4, 1'b0);
		send_word(16'sd5, 1'b0);
		send_word(-16'sd6, 1'b1);
	endtask

	// Records of seven and eight samples, with extremes inside the window.
	task automatic test_full_windows();
		send_word(16'sh7fff, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sd0, 1'b0);
		send_word(-16'sd1, 1'b0);
		send_word(16'sh7fff, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sd1, 1'b1);
		send_word(16'sd5, 1'b0);
		send_word(16'sd5, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sh7fff, 1'b0);
		send_word(16'sd5, 1'b0);
		send_word(-16'sd1, 1'b0);
		send_word(-16'sd1, 1'b0);
		send_word(16'sd0, 1'b1);
	endtask

	// Random records, mostly long enough to produce medians.
	task automatic test_random_records(input int unsigned quota);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(99);
			if (pick < 15)
				len = $urandom_range(6, 1);
			else if (pick < 95)
				len = $urandom_range(30, 7);
			else
				len = $urandom_range(70, 40);
			send_record_of(len, $urandom_range(3));
			sent += len;
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the block fills.
	task automatic test_backpressure();
		set_idle(0, 0);
		hold_left = 80;
		send_record_of(12, 0);
		send_record_of(3, 1);
		send_record_of(15, 3);
		wait_drained();
	endtask

	// Sender pauses mid-record until all expected words are out, then goes on.
	task automatic test_drain_pause();
		set_idle(20, 20);
		for (int i = 0; i < 9; i++)
			send_word(random_sample(0), 1'b0);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		for (int i = 0; i < 5; i++)
			send_word(random_sample(1), i == 4);
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < WIN_LEN; i++)
			model_win[i] = '0;
		model_pos = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_idle(32, 51);
		test_short_records();
		test_full_windows();
		test_random_records(140);
		wait_drained();
		set_idle(51, 32);
		test_random_records(140);
		wait_drained();
		set_idle(0, 0);
		test_random_records(140);
		wait_drained();
		test_backpressure();
		test_drain_pause();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived",
				expected_words.size()));

		$display("fed %0d samples in %0d records under three idle mixes, a long hold-off",
			words_fed, records_fed);
		$display("and a mid-record pause; checked %0d words (%0d medians), %0d errors",
			words_checked, medians_seen, error_count);
		if (error_count == 0) begin
			$display("sliding_median_filter_7_unit: match");
		end else begin
			$display("sliding_median_filter_7_unit: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/smf7_pkg.sv
rtl/smf7_median.sv
rtl/smf7_window.sv
rtl/smf7_emit.sv
rtl/sliding_median_filter_7_unit.sv
tb/sv/tb_sliding_median_filter_7_unit.sv
